>>> hw/rtl/key_hotkey_filter_router_defines.svh
// Assertion macros for the key hotkey router.
// KHFR_ASSERT_IMP: same-cycle implication, KHFR_ASSERT_NXT: next-cycle implication.
`ifndef KEY_HOTKEY_FILTER_ROUTER_DEFINES_SVH
`define KEY_HOTKEY_FILTER_ROUTER_DEFINES_SVH

`ifndef SYNTHESIS
`define KHFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("khfr check failed");
`define KHFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("khfr check failed");
`else
`define KHFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KHFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/khfr_pkg.sv
package khfr_pkg;

    localparam int KEY_COUNT = 256;
    localparam int KEY_W     = $clog2(KEY_COUNT);
    localparam int SCAN_W    = 9;
    localparam int TGT_W     = 4;
    localparam int MODE_W    = 3;
    localparam int HK_COUNT  = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 8;
    localparam int TDATA_W   = 32;

    localparam logic [KEY_W-1:0] KEY_CTRL   = 8'h11;
    localparam logic [KEY_W-1:0] KEY_LCTRL  = 8'hA2;
    localparam logic [KEY_W-1:0] KEY_RCTRL  = 8'hA3;
    localparam logic [KEY_W-1:0] KEY_ALT    = 8'h12;
    localparam logic [KEY_W-1:0] KEY_LALT   = 8'hA4;
    localparam logic [KEY_W-1:0] KEY_RALT   = 8'hA5;
    localparam logic [KEY_W-1:0] KEY_SHIFT  = 8'h10;
    localparam logic [KEY_W-1:0] KEY_LSHIFT = 8'hA0;
    localparam logic [KEY_W-1:0] KEY_RSHIFT = 8'hA1;
    localparam logic [KEY_W-1:0] KEY_V      = 8'h56;

    localparam logic [MODE_W-1:0] MODE_CTRL     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALT      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHIFT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CTRL_ALT = 3'd4;

    typedef enum logic [3:0] {
        ACT_NONE       = 4'd0,
        ACT_TOGGLE     = 4'd1,
        ACT_LOCK       = 4'd2,
        ACT_DISCONNECT = 4'd3,
        ACT_EXIT       = 4'd4,
        ACT_FWD_DOWN   = 4'd5,
        ACT_FWD_UP     = 4'd6,
        ACT_PASTE      = 4'd7,
        ACT_BUSY       = 4'd8,
        ACT_DOWNLOAD   = 4'd9
    } t_action;

    localparam t_action HK_ACT [HK_COUNT] = '{ACT_TOGGLE, ACT_LOCK, ACT_DISCONNECT, ACT_EXIT};

    typedef struct packed {
        logic [KEY_W-1:0]  key_code;
        logic [SCAN_W-1:0] scan_code;
        logic              pressed;
        logic              remote_active;
        logic              file_update_pending;
        logic              transfer_busy;
        logic              remote_files_ready;
        logic [TGT_W-1:0]  active_target;
    } t_item;

    typedef struct packed {
        t_action           action;
        logic [KEY_W-1:0]  out_key;
        logic [SCAN_W-1:0] out_scan;
        logic [TGT_W-1:0]  out_target;
        logic              consumed;
    } t_result;

    typedef struct packed {
        logic ctrl;
        logic alt;
        logic shift;
    } t_mods;

    typedef struct packed {
        logic             rd_en;
        logic [KEY_W-1:0] rd_addr;
        logic             wr_en;
        logic [KEY_W-1:0] wr_addr;
        logic             wr_data;
    } t_map_req;

    function automatic logic mods_match(input logic [MODE_W-1:0] mode, input t_mods held);
        logic want_ctrl;
        logic want_alt;
        logic want_shift;
        want_ctrl  = (mode == MODE_CTRL) || (mode == MODE_CTRL_ALT);
        want_alt   = (mode == MODE_ALT) || (mode == MODE_CTRL_ALT);
        want_shift = (mode == MODE_SHIFT);
        return (held.ctrl == want_ctrl) && (held.alt == want_alt) && (held.shift == want_shift);
    endfunction

endpackage

>>> hw/rtl/khfr_keymap.sv
module khfr_keymap (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  khfr_pkg::t_map_req            i_req,
    input  logic [khfr_pkg::KEY_W-1:0]    i_lookup_key,
    output logic                          o_down,
    output logic                          o_busy
);

    logic                       mem [khfr_pkg::KEY_COUNT];
    logic                       r_rd_data;
    logic                       r_clearing;
    logic [khfr_pkg::KEY_W-1:0] r_clr_cnt;
    logic                       r_fwd_vld;
    logic [khfr_pkg::KEY_W-1:0] r_fwd_key;
    logic                       r_fwd_val;
    logic                       wr_en;
    logic [khfr_pkg::KEY_W-1:0] wr_addr;
    logic                       wr_data;

    // clearing pass owns the write port after reset
    assign wr_en   = r_clearing || i_req.wr_en;
    assign wr_addr = r_clearing ? r_clr_cnt : i_req.wr_addr;
    assign wr_data = r_clearing ? 1'b0 : i_req.wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == {khfr_pkg::KEY_W{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // hold the latest write to cover a read issued on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (i_req.wr_en && !r_clearing) begin
            r_fwd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && !r_clearing) begin
            r_fwd_key <= i_req.wr_addr;
            r_fwd_val <= i_req.wr_data;
        end
    end

    assign o_down = (r_fwd_vld && (r_fwd_key == i_lookup_key)) ? r_fwd_val : r_rd_data;
    assign o_busy = r_clearing;

endmodule

>>> hw/rtl/khfr_route.sv
module khfr_route (
    input  khfr_pkg::t_item                        i_item,
    input  logic                                   i_was_down,
    input  khfr_pkg::t_mods                        i_mods,
    input  logic [khfr_pkg::KEY_W-1:0]             i_hk_key  [khfr_pkg::HK_COUNT],
    input  logic [khfr_pkg::MODE_W-1:0]            i_hk_mods [khfr_pkg::HK_COUNT],
    output khfr_pkg::t_mods                        o_mods,
    output khfr_pkg::t_result                      o_res
);

    logic                          fresh;
    logic                          paste_combo;
    logic [khfr_pkg::HK_COUNT-1:0] hit;

    always_comb begin
        o_mods = i_mods;
        if (i_item.key_code == khfr_pkg::KEY_CTRL || i_item.key_code == khfr_pkg::KEY_LCTRL
            || i_item.key_code == khfr_pkg::KEY_RCTRL) begin
            o_mods.ctrl = i_item.pressed;
        end
        if (i_item.key_code == khfr_pkg::KEY_ALT || i_item.key_code == khfr_pkg::KEY_LALT
            || i_item.key_code == khfr_pkg::KEY_RALT) begin
            o_mods.alt = i_item.pressed;
        end
        if (i_item.key_code == khfr_pkg::KEY_SHIFT || i_item.key_code == khfr_pkg::KEY_LSHIFT
            || i_item.key_code == khfr_pkg::KEY_RSHIFT) begin
            o_mods.shift = i_item.pressed;
        end
    end

    assign fresh       = i_item.pressed && !i_was_down;
    assign paste_combo = (i_item.key_code == khfr_pkg::KEY_V) && i_item.pressed && o_mods.ctrl;

    always_comb begin
        for (int i = 0; i < khfr_pkg::HK_COUNT; i++) begin
            hit[i] = fresh && (i_hk_key[i] != '0) && (i_hk_key[i] == i_item.key_code)
                     && khfr_pkg::mods_match(i_hk_mods[i], o_mods);
        end
    end

    always_comb begin
        o_res = '{action: khfr_pkg::ACT_NONE, out_key: '0, out_scan: '0, out_target: '0,
                  consumed: 1'b0};
        if (hit != '0) begin
            o_res.consumed = 1'b1;
            // lowest hotkey wins
            for (int i = khfr_pkg::HK_COUNT - 1; i >= 0; i--) begin
                if (hit[i]) begin
                    o_res.action = khfr_pkg::HK_ACT[i];
                end
            end
        end else if (i_item.remote_active) begin
            o_res.consumed = 1'b1;
            if (paste_combo && i_item.file_update_pending) begin
                if (i_item.transfer_busy) begin
                    o_res.action = khfr_pkg::ACT_BUSY;
                end else begin
                    o_res.action     = khfr_pkg::ACT_PASTE;
                    o_res.out_target = i_item.active_target;
                end
            end else begin
                o_res.action     = i_item.pressed ? khfr_pkg::ACT_FWD_DOWN : khfr_pkg::ACT_FWD_UP;
                o_res.out_key    = i_item.key_code;
                o_res.out_scan   = i_item.scan_code;
                o_res.out_target = i_item.active_target;
            end
        end else if (paste_combo && i_item.remote_files_ready) begin
            o_res.action   = khfr_pkg::ACT_DOWNLOAD;
            o_res.consumed = 1'b1;
        end
    end

endmodule

>>> hw/rtl/key_hotkey_filter_router.sv
// Accepted transfers pass the stage 1 register, then the output register. Throughput:
// one key event per cycle unless the output stalls; the pressed-key RAM is read on
// accept and written back as stage 1 leaves, forwarding covering back-to-back hits.
// Reset: synchronous, active low; clears modifiers, hotkey registers and the pipeline,
// then sweeps the 256-entry key map with s_axis_tready low.
`include "key_hotkey_filter_router_defines.svh"

module key_hotkey_filter_router (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave side, tdata from bit 0: key_code[7:0], scan_code[16:8], pressed[17],
    // remote_active[18], file_update_pending[19], transfer_busy[20],
    // remote_files_ready[21], active_target[25:22], zero fill [31:26]
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [khfr_pkg::TDATA_W-1:0]          s_axis_tdata,
    // master side, tdata from bit 0: action[3:0], out_key[11:4], out_scan[20:12],
    // out_target[24:21], consumed[25], zero fill [31:26]
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [khfr_pkg::TDATA_W-1:0]          m_axis_tdata,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [khfr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [khfr_pkg::CFG_DAT_W-1:0]        i_cfg_data
);

    // hotkey registers: even index writes a key, odd index its modifier mode
    logic [khfr_pkg::KEY_W-1:0]  r_hk_key  [khfr_pkg::HK_COUNT];
    logic [khfr_pkg::MODE_W-1:0] r_hk_mods [khfr_pkg::HK_COUNT];
    logic [1:0]                  cfg_slot;

    khfr_pkg::t_mods   r_mods;
    khfr_pkg::t_mods   n_mods;
    khfr_pkg::t_item   in_item;
    khfr_pkg::t_item   r_s1_item;
    logic              r_s1_vld;
    khfr_pkg::t_result res;
    khfr_pkg::t_result r_out;
    logic              r_out_vld;
    khfr_pkg::t_map_req map_req;
    logic              map_down;
    logic              map_busy;
    logic              s_fire;
    logic              s1_go;
    logic              s1_fire;
    logic              out_none;
    logic              out_fwd;
    logic              out_codes_clr;

    assign o_cfg_ready = 1'b1;
    assign cfg_slot    = i_cfg_index[2:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < khfr_pkg::HK_COUNT; i++) begin
                r_hk_key[i]  <= '0;
                r_hk_mods[i] <= '0;
            end
        end else if (i_cfg_valid && !i_cfg_index[3]) begin
            // writes beyond the register list are dropped
            if (i_cfg_index[0]) begin
                r_hk_mods[cfg_slot] <= i_cfg_data[khfr_pkg::MODE_W-1:0];
            end else begin
                r_hk_key[cfg_slot] <= i_cfg_data;
            end
        end
    end

    // unpack the input transfer, lowest field first
    assign in_item.key_code            = s_axis_tdata[7:0];
    assign in_item.scan_code           = s_axis_tdata[16:8];
    assign in_item.pressed             = s_axis_tdata[17];
    assign in_item.remote_active       = s_axis_tdata[18];
    assign in_item.file_update_pending = s_axis_tdata[19];
    assign in_item.transfer_busy       = s_axis_tdata[20];
    assign in_item.remote_files_ready  = s_axis_tdata[21];
    assign in_item.active_target       = s_axis_tdata[25:22];

    // stage 1 advances when the output register is empty or being drained;
    // accept whenever the key map is idle and stage 1 is empty or advancing, so one
    // waiting result does not block the next transfer
    assign s1_go         = !r_out_vld || m_axis_tready;
    assign s1_fire       = r_s1_vld && s1_go;
    assign s_axis_tready = !map_busy && (!r_s1_vld || s1_go);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // read the map entry on accept, write the new pressed state as stage 1 leaves
    assign map_req.rd_en   = s_fire;
    assign map_req.rd_addr = in_item.key_code;
    assign map_req.wr_en   = s1_fire;
    assign map_req.wr_addr = r_s1_item.key_code;
    assign map_req.wr_data = r_s1_item.pressed;

    khfr_keymap u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (map_req),
        .i_lookup_key (r_s1_item.key_code),
        .o_down       (map_down),
        .o_busy       (map_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_fire) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1_item <= in_item;
        end
    end

    khfr_route u_route (
        .i_item     (r_s1_item),
        .i_was_down (map_down),
        .i_mods     (r_mods),
        .i_hk_key   (r_hk_key),
        .i_hk_mods  (r_hk_mods),
        .o_mods     (n_mods),
        .o_res      (res)
    );

    // modifiers commit together with the map write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mods <= '0;
        end else if (s1_fire) begin
            r_mods <= n_mods;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out.consumed, r_out.out_target, r_out.out_scan,
                            r_out.out_key, r_out.action};

    assign out_none      = (r_out.action == khfr_pkg::ACT_NONE);
    assign out_fwd       = (r_out.action == khfr_pkg::ACT_FWD_DOWN)
                           || (r_out.action == khfr_pkg::ACT_FWD_UP);
    assign out_codes_clr = (r_out.out_key == '0) && (r_out.out_scan == '0);

    // a result held in stage 1 is never dropped while the output stalls
    `KHFR_ASSERT_NXT(a_s1_hold, i_clk, i_rst_n, r_s1_vld && !s1_go, r_s1_vld)
    // nothing enters while the key map is being swept
    `KHFR_ASSERT_IMP(a_no_accept_clear, i_clk, i_rst_n, map_busy, !s_fire)
    // a pass-through result carries no action
    `KHFR_ASSERT_IMP(a_pass_none, i_clk, i_rst_n, r_out_vld && !r_out.consumed, out_none)
    // key and scan codes appear only on forwarded events
    `KHFR_ASSERT_IMP(a_fwd_only, i_clk, i_rst_n, r_out_vld && !out_fwd, out_codes_clr)

endmodule
